[src/bbpe_pkg.sv]
// Shared types, constants and controller command bundle for the Bezier patch evaluator.
package bbpe_pkg;

  localparam int COORD_W    = 32;
  localparam int PARAM_FRAC = 16;
  localparam int PARAM_W    = PARAM_FRAC + 1;
  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int NUM_AXES   = 3;
  localparam int NUM_WGT    = 4;
  localparam int WIDX_W     = $clog2(NUM_WGT);

  // Weight unit: t*t style product, then times c, or 3*c for the middle weights
  localparam int WPROD_W = 2 * PARAM_W;
  localparam int WMUL_W  = WPROD_W + PARAM_W + 2;
  // Term of the sum: signed coordinate times unsigned weight product
  localparam int TERM_W  = COORD_W + WPROD_W + 1;
  // Sum of sixteen terms, weight products sum to at most 1.0
  localparam int ACC_W   = COORD_W + 2 * PARAM_FRAC + 2;
  localparam int SHR_W   = ACC_W - 2 * PARAM_FRAC;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [SLOT_W-1:0]         point_slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [PARAM_W-1:0]        param_u;
    logic [PARAM_W-1:0]        param_v;
  } eval_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] surf_x;
    logic signed [COORD_W-1:0] surf_y;
    logic signed [COORD_W-1:0] surf_z;
    logic                      clipped;
  } eval_out_t;

  typedef struct packed {
    logic              load;
    logic              take_params;
    logic              acc_clear;
    logic              w_issue;
    logic [WIDX_W-1:0] w_idx;
    logic              mac_issue;
    logic [SLOT_W-1:0] mac_idx;
    logic              finish;
  } ctrl_cmd_t;

endpackage

[src/bbpe_ctrl.sv]
// Sequencer: runs weight generation, the sixteen-step accumulation and the final rounding.
module bbpe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                operation_i,
  output logic                busy,
  output bbpe_pkg::ctrl_cmd_t cmd_o
);
  import bbpe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WGT  = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Counter reaches the last MAC issue step plus the drain steps
  localparam int CNT_W    = $clog2(NUM_SLOTS + 2);
  // Four issues plus a final step for the second weight stage
  localparam int WGT_LAST = NUM_WGT;
  // Sixteen issues plus a two-stage drain (read/product, then term)
  localparam int MAC_LAST = NUM_SLOTS + 1;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load        = accept && (operation_i == OP_LOAD);
        cmd_o.take_params = accept && (operation_i == OP_EVAL);
        cmd_o.acc_clear   = accept && (operation_i == OP_EVAL);
        if (accept && (operation_i == OP_EVAL)) begin
          state_d = ST_WGT;
          cnt_d   = '0;
        end
      end
      ST_WGT: begin
        cmd_o.w_issue = (cnt_q < CNT_W'(NUM_WGT));
        cmd_o.w_idx   = cnt_q[WIDX_W-1:0];
        if (cnt_q == CNT_W'(WGT_LAST)) begin
          state_d = ST_MAC;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = (cnt_q < CNT_W'(NUM_SLOTS));
        cmd_o.mac_idx   = cnt_q[SLOT_W-1:0];
        if (cnt_q == CNT_W'(MAC_LAST)) begin
          state_d = ST_FIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[src/bbpe_dp.sv]
// Datapath: control point store, Bernstein weight pipes, three MAC lanes, round and saturate.
module bbpe_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bbpe_pkg::ctrl_cmd_t  cmd_i,
  input  bbpe_pkg::eval_in_t   in_i,
  output logic                 done_o,
  output bbpe_pkg::eval_out_t  res_o
);
  import bbpe_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (2 * PARAM_FRAC - 1);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // ---- control point store ----
  logic [NUM_AXES-1:0][COORD_W-1:0] store_q [NUM_SLOTS];
  logic [NUM_AXES-1:0][COORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_q[in_i.point_slot] <= {in_i.coord_z, in_i.coord_y, in_i.coord_x};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= store_q[cmd_i.mac_idx];
  end

  // ---- parameters, clamped to 1.0; lane 0 is u, lane 1 is v ----
  logic [1:0][PARAM_W-1:0] prm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_params) begin
      prm_q[0] <= (in_i.param_u > PARAM_ONE) ? PARAM_ONE : in_i.param_u;
      prm_q[1] <= (in_i.param_v > PARAM_ONE) ? PARAM_ONE : in_i.param_v;
    end
  end

  // ---- weight pipes: stage 1 a*b, stage 2 times (3)c, keep floor ----
  logic [1:0][NUM_WGT-1:0][PARAM_W-1:0] wgt_q;
  logic [1:0][WPROD_W-1:0]              p1_q;
  logic [WIDX_W-1:0]                    idx1_q;
  logic                                 v1_q;

  for (genvar ln = 0; ln < 2; ln++) begin : g_wlane
    logic [PARAM_W-1:0]   t_l, s_l, opa, opb, c_l;
    logic [PARAM_W+1:0]   c3;
    logic [WMUL_W-1:0]    m2;

    assign t_l = prm_q[ln];
    assign s_l = PARAM_ONE - t_l;
    // w0 = s*s*s, w1 = 3*t*s*s, w2 = 3*t*t*s, w3 = t*t*t
    assign opa = (cmd_i.w_idx == WIDX_W'(0)) ? s_l : t_l;
    assign opb = (cmd_i.w_idx <= WIDX_W'(1)) ? s_l : t_l;
    assign c_l = (idx1_q == WIDX_W'(3)) ? t_l : s_l;
    assign c3  = ((idx1_q == WIDX_W'(1)) || (idx1_q == WIDX_W'(2)))
               ? ({2'b00, c_l} + {1'b0, c_l, 1'b0}) : {2'b00, c_l};
    assign m2  = WMUL_W'(p1_q[ln]) * WMUL_W'(c3);

    always_ff @(posedge clk_i) begin
      if (cmd_i.w_issue) begin
        p1_q[ln] <= WPROD_W'(opa) * WPROD_W'(opb);
      end
      if (v1_q) begin
        wgt_q[ln][idx1_q] <= m2[2*PARAM_FRAC +: PARAM_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_issue) begin
      idx1_q <= cmd_i.w_idx;
    end
  end

  // ---- MAC pipeline: A read + weight product, B terms, C accumulate ----
  logic                                 va_q, vb_q;
  logic [WPROD_W-1:0]                   wuv_q;
  logic [NUM_AXES-1:0][TERM_W-1:0]      term_q;
  logic [NUM_AXES-1:0][ACC_W-1:0]       acc_q;
  logic [NUM_AXES-1:0][COORD_W-1:0]     sat_w;
  logic [NUM_AXES-1:0]                  clip_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_issue) begin
      wuv_q <= WPROD_W'(wgt_q[0][cmd_i.mac_idx[SLOT_W-1 -: WIDX_W]])
             * WPROD_W'(wgt_q[1][cmd_i.mac_idx[WIDX_W-1:0]]);
    end
  end

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    logic signed [TERM_W-1:0] term_d;
    logic signed [SHR_W-1:0]  shr;
    logic [ACC_W-1:0]         rnd;
    logic                     fits;

    assign term_d = $signed(rd_q[ax]) * $signed({1'b0, wuv_q});
    assign rnd    = acc_q[ax] + ACC_HALF;
    assign shr    = $signed(rnd[ACC_W-1 -: SHR_W]);
    // in range when the bits above the coordinate sign all agree with it
    assign fits   = (shr[SHR_W-1:COORD_W-1] == '0) || (shr[SHR_W-1:COORD_W-1] == '1);

    always_ff @(posedge clk_i) begin
      if (va_q) begin
        term_q[ax] <= term_d;
      end
      if (cmd_i.acc_clear) begin
        acc_q[ax] <= '0;
      end else if (vb_q) begin
        acc_q[ax] <= acc_q[ax] + term_q[ax][ACC_W-1:0];
      end
    end

    assign sat_w[ax]  = fits ? shr[COORD_W-1:0] : (shr[SHR_W-1] ? COORD_MIN : COORD_MAX);
    assign clip_w[ax] = !fits;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_o.surf_x  <= sat_w[0];
      res_o.surf_y  <= sat_w[1];
      res_o.surf_z  <= sat_w[2];
      res_o.clipped <= |clip_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= cmd_i.w_issue;
      va_q   <= cmd_i.mac_issue;
      vb_q   <= va_q;
      done_o <= cmd_i.finish;
    end
  end

endmodule

[src/bicubic_bezier_patch_eval_top.sv]
// Top level of the bicubic Bezier patch evaluator: sequencer plus datapath.
//
//  channel  | ports                      | transaction
//  ---------+----------------------------+------------------------------------------
//  command  | start, busy, in_i          | taken at a rising edge with start & !busy
//  result   | done_o, res_o              | one-cycle strobe, taken at the edge ending it
//
// A load transaction writes one control point; busy stays low. An evaluate
// transaction keeps busy high while it runs the four Bernstein weights of u
// and v through the two-stage weight pipes, streams the sixteen control
// points through the shared MAC lanes (one store read per cycle, then a drain)
// and finally rounds and saturates. done_o pulses in the same cycle that busy
// falls; a new transaction may be taken in that same cycle. Reset is
// asynchronous, active low, and clears only the sequencer and the pipeline
// valids; the control point store is not cleared and must be fully loaded
// before the first evaluation. The result side has no back-pressure:
// results are presented once and are lost if not sampled.
module bicubic_bezier_patch_eval_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bbpe_pkg::eval_in_t  in_i,
  output logic                done_o,
  output bbpe_pkg::eval_out_t res_o
);
  import bbpe_pkg::*;

  ctrl_cmd_t cmd;

  // sequencing: load writes, weight issue, MAC issue, finish
  bbpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (in_i.operation),
    .busy        (busy),
    .cmd_o       (cmd)
  );

  // arithmetic and control point storage
  bbpe_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the bicubic Bezier patch evaluator top level.
module tb_top;
  import bbpe_pkg::*;

  localparam int RAND_ITEMS    = 1250;
  localparam int RELOAD_EVERY  = 250;  // a fresh patch is loaded this often
  localparam int SETTLE_CYCLES = 32;
  localparam int SHOW_MAX      = 10;

  // Fixed point limits for the surface predictor, kept wide to hold the exact sum
  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (2 * PARAM_FRAC - 1);
  localparam logic signed [127:0] SAT_HI     = (128'sd1 <<< (COORD_W - 1)) - 128'sd1;
  localparam logic signed [127:0] SAT_LO     = -(128'sd1 <<< (COORD_W - 1));

  typedef logic [NUM_WGT-1:0][PARAM_W-1:0] wgt_set_t;

  // One stimulus row; want is used only where typed is set
  typedef struct {
    eval_in_t  item;
    bit        typed;
    eval_out_t want;
  } stim_row_t;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      cmd_start  = 1'b0;
  logic      cmd_busy;
  eval_in_t  cmd_item   = '0;
  logic      res_strobe;
  eval_out_t res_item;

  // Predictor copy of the control point store and the surface points still owed
  logic signed [COORD_W-1:0] patch_pts [NUM_SLOTS][NUM_AXES];
  eval_out_t                 surf_due [$];

  int err_cnt  = 0;
  int load_cnt = 0;
  int eval_cnt = 0;
  int res_cnt  = 0;
  bit no_idle  = 1'b0;  // when set the sender issues back to back

  always #2 clk_i = ~clk_i;

  bicubic_bezier_patch_eval_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (cmd_start),
    .busy   (cmd_busy),
    .in_i   (cmd_item),
    .done_o (res_strobe),
    .res_o  (res_item)
  );

  // Cubic Bernstein weights, each the exact value floored to Q1.16.
  // A parameter above one is clamped to one first.
  function automatic wgt_set_t bernstein_wgts(logic [PARAM_W-1:0] t_in);
    logic [63:0] t;
    logic [63:0] s;
    wgt_set_t    w;
    t = (t_in > PARAM_ONE) ? 64'(PARAM_ONE) : 64'(t_in);
    s = 64'(PARAM_ONE) - t;
    w[0] = PARAM_W'((s * s * s) >> (2 * PARAM_FRAC));
    w[1] = PARAM_W'((64'd3 * t * s * s) >> (2 * PARAM_FRAC));
    w[2] = PARAM_W'((64'd3 * t * t * s) >> (2 * PARAM_FRAC));
    w[3] = PARAM_W'((t * t * t) >> (2 * PARAM_FRAC));
    return w;
  endfunction

  // Surface point at (u, v) from the current patch: exact wide sum of the
  // sixteen weighted points, rounded half up, then saturated.
  function automatic eval_out_t surface_point(logic [PARAM_W-1:0] u, logic [PARAM_W-1:0] v);
    wgt_set_t                           wu;
    wgt_set_t                           wv;
    logic signed [127:0]                acc;
    logic signed [127:0]                pt;
    logic signed [127:0]                wgt;
    logic [NUM_AXES-1:0][COORD_W-1:0]   crd;
    eval_out_t                          res;
    res = '0;
    wu  = bernstein_wgts(u);
    wv  = bernstein_wgts(v);
    for (int c = 0; c < NUM_AXES; c++) begin
      acc = '0;
      for (int a = 0; a < NUM_WGT; a++) begin
        for (int b = 0; b < NUM_WGT; b++) begin
          pt  = patch_pts[a * NUM_WGT + b][c];
          wgt = wu[a] * wv[b];
          acc = acc + pt * wgt;
        end
      end
      acc = (acc + ROUND_HALF) >>> (2 * PARAM_FRAC);
      // weights are non-negative and sum to at most one, so this rarely bites
      if (acc > SAT_HI) begin
        crd[c]      = SAT_HI[COORD_W-1:0];
        res.clipped = 1'b1;
      end else if (acc < SAT_LO) begin
        crd[c]      = SAT_LO[COORD_W-1:0];
        res.clipped = 1'b1;
      end else begin
        crd[c] = acc[COORD_W-1:0];
      end
    end
    res.surf_x = crd[0];
    res.surf_y = crd[1];
    res.surf_z = crd[2];
    return res;
  endfunction

  function automatic stim_row_t load_row(int slot, logic [COORD_W-1:0] x, y, z,
                                         logic [PARAM_W-1:0] u, v);
    stim_row_t row;
    row.item.operation  = OP_LOAD;
    row.item.point_slot = SLOT_W'(slot);
    row.item.coord_x    = x;
    row.item.coord_y    = y;
    row.item.coord_z    = z;
    row.item.param_u    = u;
    row.item.param_v    = v;
    row.typed           = 1'b0;
    row.want            = '0;
    return row;
  endfunction

  // Evaluate row; slot and filler go to the fields the block should ignore
  function automatic stim_row_t eval_row(logic [PARAM_W-1:0] u, v, int slot,
                                         logic [COORD_W-1:0] filler, bit typed,
                                         logic [COORD_W-1:0] ex, ey, ez);
    stim_row_t row;
    row.item.operation  = OP_EVAL;
    row.item.point_slot = SLOT_W'(slot);
    row.item.coord_x    = filler;
    row.item.coord_y    = ~filler;
    row.item.coord_z    = filler ^ 32'h5A5A_A5A5;
    row.item.param_u    = u;
    row.item.param_v    = v;
    row.typed           = typed;
    row.want            = '0;
    row.want.surf_x     = ex;
    row.want.surf_y     = ey;
    row.want.surf_z     = ez;
    return row;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 6))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PARAM_ONE;
      2:       return PARAM_W'($urandom_range(32'h1_0001, 32'h1_FFFF));
      3:       return PARAM_W'($urandom_range(0, 15));
      4:       return PARAM_ONE - PARAM_W'($urandom_range(1, 16));
      default: return PARAM_W'($urandom_range(0, 32'h1_0000));
    endcase
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t row;
    row.item.operation  = ($urandom_range(0, 99) < 55) ? OP_EVAL : OP_LOAD;
    row.item.point_slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    row.item.coord_x    = rand_coord();
    row.item.coord_y    = rand_coord();
    row.item.coord_z    = rand_coord();
    row.item.param_u    = rand_param();
    row.item.param_v    = rand_param();
    row.typed           = 1'b0;
    row.want            = '0;
    return row;
  endfunction

  // Mostly no gap, some short ones, the odd long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Present one transaction and hold it until the block takes it.
  // busy is read just after the edge, so it is the value the block saw.
  task automatic issue(stim_row_t row);
    int gap;
    cmd_start <= 1'b1;
    cmd_item  <= row.item;
    do @(posedge clk_i); while (cmd_busy);
    if (row.item.operation == OP_LOAD) begin
      patch_pts[row.item.point_slot][0] = row.item.coord_x;
      patch_pts[row.item.point_slot][1] = row.item.coord_y;
      patch_pts[row.item.point_slot][2] = row.item.coord_z;
      load_cnt++;
    end else begin
      surf_due.insert(surf_due.size(),
                      row.typed ? row.want
                                : surface_point(row.item.param_u, row.item.param_v));
      eval_cnt++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      cmd_start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender holds off until every owed surface point has come back
  task automatic drain_results();
    cmd_start <= 1'b0;
    do @(posedge clk_i); while (surf_due.size() != 0);
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= SHOW_MAX)
        $display("[%0t] %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Result side: a strobe cannot be held off, so every one is checked as it passes
  always @(posedge clk_i) begin : result_check
    eval_out_t want;
    if (rst_ni && res_strobe) begin
      res_cnt++;
      if (surf_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOW_MAX)
          $display("[%0t] result transaction with nothing outstanding: %h", $time, res_item);
      end else begin
        want = surf_due.pop_front();
        check_field("surf_x", want.surf_x, res_item.surf_x);
        check_field("surf_y", want.surf_y, res_item.surf_y);
        check_field("surf_z", want.surf_z, res_item.surf_z);
        check_field("clipped", COORD_W'(want.clipped), COORD_W'(res_item.clipped));
      end
    end
  end

  initial begin : stimulus
    stim_row_t dir_tab [$];
    int        next_reload;
    int        n;
    bit        drained;

    // Directed table. The store comes up undefined, so all sixteen slots are
    // loaded before the first evaluation. Corner parameters pick a single
    // control point exactly, so those rows carry their answer.
    dir_tab.insert(dir_tab.size(), load_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                            17'h1_FFFF, 17'h0_AAAA));
    for (int i = 1; i < NUM_SLOTS - 1; i++)
      dir_tab.insert(dir_tab.size(), load_row(i, i << 16, -(i << 16), i, '0, '0));
    dir_tab.insert(dir_tab.size(), load_row(15, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                                            17'h1_0000, 17'h0_0001));
    // u = v = 0: first point, at both coordinate extremes
    dir_tab.insert(dir_tab.size(), eval_row(17'h0_0000, 17'h0_0000, 15, 32'hDEAD_BEEF, 1'b1,
                                            32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000));
    // u = v = 1: last point
    dir_tab.insert(dir_tab.size(), eval_row(17'h1_0000, 17'h1_0000, 7, 32'h0000_0000, 1'b1,
                                            32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000));
    // parameters above one clamp to one
    dir_tab.insert(dir_tab.size(), eval_row(17'h1_FFFF, 17'h1_FFFF, 0, 32'hFFFF_FFFF, 1'b1,
                                            32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000));
    // u = 0, v = 1: corner slot 3
    dir_tab.insert(dir_tab.size(), eval_row(17'h0_0000, 17'h1_0000, 12, 32'h1234_5678, 1'b1,
                                            32'h0003_0000, 32'hFFFD_0000, 32'h0000_0003));
    // u = 1, v = 0: corner slot 12
    dir_tab.insert(dir_tab.size(), eval_row(17'h1_0000, 17'h0_0000, 3, 32'h8765_4321, 1'b1,
                                            32'h000C_0000, 32'hFFF4_0000, 32'h0000_000C));
    // interior points go through the predictor
    dir_tab.insert(dir_tab.size(), eval_row(17'h0_8000, 17'h0_8000, 5, 32'h0F0F_0F0F, 1'b0,
                                            '0, '0, '0));
    dir_tab.insert(dir_tab.size(), eval_row(17'h0_0001, 17'h0_FFFF, 10, 32'hF0F0_F0F0, 1'b0,
                                            '0, '0, '0));
    // rewrite a loaded slot, then read it back at the corner
    dir_tab.insert(dir_tab.size(), load_row(0, '0, '0, '0, 17'h1_5555, 17'h0_FFFF));
    dir_tab.insert(dir_tab.size(), eval_row(17'h0_0000, 17'h0_0000, 15, 32'h7FFF_FFFF, 1'b1,
                                            '0, '0, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) issue(dir_tab[k]);
    drain_results();

    // Random part: a fresh patch now and then, otherwise a mix of single
    // point updates and evaluations; one pause midway lets the block go idle.
    next_reload = 0;
    drained     = 1'b0;
    n           = 0;
    while (n < RAND_ITEMS) begin
      if (n >= next_reload) begin
        for (int s = 0; s < NUM_SLOTS; s++)
          issue(load_row(s, rand_coord(), rand_coord(), rand_coord(),
                         rand_param(), rand_param()));
        n           += NUM_SLOTS;
        next_reload += RELOAD_EVERY;
      end else if (!drained && n >= RAND_ITEMS / 2) begin
        drain_results();
        drained = 1'b1;
      end else begin
        if ($urandom_range(0, 99) == 0) no_idle = ~no_idle;
        issue(rand_row());
        n++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d control point loads and %0d evaluations, %0d results checked.",
             load_cnt, eval_cnt, res_cnt);
    $display("Parameters took zero, one, above one and interior values; coords hit both rails.");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Generous bound on the whole run
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding", surf_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
